FILE: rtl/bdda_pkg.sv
// bdda_pkg: shared constants, state codes and calendar tables for the
// business-day date adder. No dependencies.

package bdda_pkg;

  // default width of the business-day count
  localparam int DEF_COUNT_WIDTH = 16;

  // days in a hundred-year cycle (every fourth year leap)
  localparam int CYCLE_DAYS = 36525;
  // days in any run of 48 consecutive months
  localparam int QUAD_DAYS  = 1461;
  localparam int YEAR_DAYS  = 365;
  localparam int LAST_YEAR  = 99;
  localparam int DAYS_WEEK  = 7;
  // weekday bias: 2000-01-01 is a saturday
  localparam int WD_BIAS    = 5;

  // reset value of the weekday mask (monday to friday)
  localparam logic [6:0] MASK_RESET = 7'd62;

  // sequencer codes
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_WMOD = 4'd1;
  localparam logic [3:0] S_CDEC = 4'd2;
  localparam logic [3:0] S_DIV  = 4'd3;
  localparam logic [3:0] S_POS  = 4'd4;
  localparam logic [3:0] S_MUL7 = 4'd5;
  localparam logic [3:0] S_OFFD = 4'd6;
  localparam logic [3:0] S_CMP1 = 4'd7;
  localparam logic [3:0] S_RDEC = 4'd8;
  localparam logic [3:0] S_RMOD = 4'd9;
  localparam logic [3:0] S_RINC = 4'd10;
  localparam logic [3:0] S_QUAD = 4'd11;
  localparam logic [3:0] S_YEAR = 4'd12;
  localparam logic [3:0] S_MON  = 4'd13;
  localparam logic [3:0] S_DONE = 4'd14;

  // length of month m (1..12), leap selects 29-day february
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = 5'd31;
    endcase
    return len;
  endfunction

  // days before month m in a common year, modulo 7
  function automatic logic [2:0] month_cum7(input logic [3:0] m);
    logic [2:0] c;
    case (m)
      4'd2, 4'd3, 4'd11: c = 3'd3;
      4'd4, 4'd7:        c = 3'd6;
      4'd5:              c = 3'd1;
      4'd6:              c = 3'd4;
      4'd8:              c = 3'd2;
      4'd9, 4'd12:       c = 3'd5;
      default:           c = 3'd0;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/business_day_date_adder.sv
// business_day_date_adder: adds a count of business days to a calendar date
// with one shared add/subtract unit under a small sequencer.
// Depends on bdda_pkg.
//
// Usage:
//   in_*  channel: one request per start date and business-day count. in_tready
//         is high only while the sequencer is idle; a request is taken when
//         in_tvalid and in_tready are both high.
//   out_* channel: one result per request, held in an output register until
//         out_tready; a new request may be taken while that result waits.
//   cfg_*: cfg_wr_en writes the 7-bit weekday mask (bit0 sunday) at the edge;
//         write it only while no request is in flight.
// The one shared adder works through weekday reduction (1 to 24 steps of
//   minus 7), restoring division of the count by the number of business
//   weekdays (COUNT_WIDTH steps), a scan of 1 to 7 weekdays, reduction modulo
//   36525 (COUNT_WIDTH+4 steps), then a walk of up to 24 four-year spans, 3
//   years and 11 months. An empty-mask error ends after the weekday reduction;
//   a zero count skips the division and scan, and a result that stays in the
//   start month skips the reduction modulo 36525 and the walk.
// One request at a time; the next can be taken in the cycle after the
//   result is loaded. Reset (rst_n low, synchronous): idle, no result, mask 62.
// A stalled receiver only holds the finished result; the next one waits in
// the sequencer until the output register is free.

module business_day_date_adder
  import bdda_pkg::*;
#(
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH,
  localparam int IN_W = ((16 + COUNT_WIDTH + 7) / 8) * 8
) (
  input  logic            clk,
  input  logic            rst_n,
  // request: start_month[3:0], start_day[8:4], start_year[15:9],
  //          business_count[16+COUNT_WIDTH-1:16], zero fill above
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [IN_W-1:0] in_tdata,
  // result: end_month[3:0], end_day[8:4], end_year[15:9],
  //         start_weekday[18:16], zero fill above
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [23:0]     out_tdata,
  // result flag: mask_error[0]
  output logic            out_tuser,
  input  logic            cfg_wr_en,
  input  logic [6:0]      cfg_wr_data
);

  localparam int CW    = COUNT_WIDTH;
  localparam int ACC_W = CW + 4;
  localparam int UW    = (ACC_W > 17) ? ACC_W : 17;
  localparam int CNT_W = $clog2(ACC_W + 1);

  // control state
  logic [3:0]       state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [6:0]       mask_r;
  // working registers
  logic [3:0]       raw_m_r, raw_m_nxt, m_r, m_nxt;
  logic [4:0]       raw_d_r, raw_d_nxt, end_day_r, end_day_nxt;
  logic [6:0]       raw_y_r, raw_y_nxt, y_r, y_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             err_r, err_nxt;
  logic [2:0]       wd_r, wd_nxt, r_r, r_nxt, ptr_r, ptr_nxt, pos_r, pos_nxt;
  logic [UW-1:0]    acc_r, acc_nxt;
  logic [15:0]      rmd_r, rmd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [18:0]      out_data_r, out_data_nxt;
  logic             out_err_r, out_err_nxt;

  // request fields
  logic [3:0]    in_m;
  logic [4:0]    in_d;
  logic [6:0]    in_y;
  logic [CW-1:0] in_cnt;
  assign in_m   = in_tdata[3:0];
  assign in_d   = in_tdata[8:4];
  assign in_y   = in_tdata[15:9];
  assign in_cnt = in_tdata[16 +: CW];

  // clamped month and year and the weekday sum before reduction
  logic [3:0] m_c;
  logic [6:0] y_c;
  logic       leap_adj;
  logic [7:0] wsum;
  always_comb begin
    m_c = in_m;
    if (in_m == 4'd0) m_c = 4'd1;
    else if (in_m > 4'd12) m_c = 4'd12;
    y_c = (in_y > 7'(LAST_YEAR)) ? in_y - 7'd100 : in_y;
    leap_adj = (y_c[1:0] == 2'd0) && (m_c > 4'd2);
    wsum = 8'(y_c) + 8'((8'(y_c) + 8'd3) >> 2) + 8'(month_cum7(m_c))
         + 8'(leap_adj) + 8'(in_d) + 8'(WD_BIAS);
  end

  // derived control values
  logic [2:0] kdays;
  logic       leap_cur, leap_span;
  logic [4:0] len_cur;
  logic [1:0] feb_y;
  logic [5:0] small_add;
  assign kdays     = 3'($countones(mask_r));
  assign leap_cur  = (y_r[1:0] == 2'd0);
  assign len_cur   = month_len(m_r, leap_cur);
  assign feb_y     = y_r[1:0] + {1'b0, (m_r > 4'd2)};
  assign leap_span = (feb_y == 2'd0);
  assign small_add = 6'(pos_r) + 6'(mask_r[wd_r]) + 6'(raw_d_r);

  // shared add/subtract unit
  logic [UW-1:0] ua, ub, udiff;
  logic          usub, uge, ugt;
  logic [UW:0]   usum;
  always_comb begin
    ua   = '0;
    ub   = '0;
    usub = 1'b1;
    unique case (state_r)
      S_WMOD: begin
        ua = acc_r;
        ub = UW'(DAYS_WEEK);
      end
      S_CDEC: begin
        ua = UW'(count_r);
        ub = UW'(1);
      end
      S_DIV: begin
        ua = UW'({rmd_r[2:0], count_r[CW-1]});
        ub = UW'(kdays);
      end
      S_MUL7: begin
        ua = UW'({count_r, 3'b000});
        ub = UW'(count_r);
      end
      S_OFFD: begin
        ua   = acc_r;
        ub   = UW'(small_add);
        usub = 1'b0;
      end
      S_CMP1, S_MON: begin
        ua = acc_r;
        ub = UW'(len_cur);
      end
      S_RDEC: begin
        ua = acc_r;
        ub = UW'(1);
      end
      S_RMOD: begin
        ua = UW'({rmd_r, acc_r[ACC_W-1]});
        ub = UW'(CYCLE_DAYS);
      end
      S_RINC: begin
        ua   = UW'(rmd_r);
        ub   = UW'(1);
        usub = 1'b0;
      end
      S_QUAD: begin
        ua = acc_r;
        ub = UW'(QUAD_DAYS);
      end
      S_YEAR: begin
        ua = acc_r;
        ub = UW'(YEAR_DAYS) + UW'(leap_span);
      end
      default: begin
        ua = '0;
        ub = '0;
      end
    endcase
    usum  = {1'b0, ua} + {1'b0, (usub ? ~ub : ub)} + (UW + 1)'(usub);
    udiff = usum[UW-1:0];
    uge   = usum[UW];
    ugt   = uge && (udiff != '0);
  end

  // month step with year wrap
  logic [3:0] m_inc;
  logic [6:0] y_inc, y_quad;
  always_comb begin
    if (m_r == 4'd12) begin
      m_inc = 4'd1;
      y_inc = (y_r == 7'(LAST_YEAR)) ? 7'd0 : y_r + 7'd1;
    end else begin
      m_inc = m_r + 4'd1;
      y_inc = y_r;
    end
    y_quad = (y_r > 7'd95) ? y_r - 7'd96 : y_r + 7'd4;
  end

  assign in_tready = (state_r == S_IDLE);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    raw_m_nxt     = raw_m_r;
    raw_d_nxt     = raw_d_r;
    raw_y_nxt     = raw_y_r;
    m_nxt         = m_r;
    y_nxt         = y_r;
    count_nxt     = count_r;
    err_nxt       = err_r;
    wd_nxt        = wd_r;
    r_nxt         = r_r;
    ptr_nxt       = ptr_r;
    pos_nxt       = pos_r;
    acc_nxt       = acc_r;
    rmd_nxt       = rmd_r;
    cnt_nxt       = cnt_r;
    end_day_nxt   = end_day_r;
    out_data_nxt  = out_data_r;
    out_err_nxt   = out_err_r;

    // result taken
    if (out_valid_r && out_tready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          raw_m_nxt = in_m;
          raw_d_nxt = in_d;
          raw_y_nxt = in_y;
          m_nxt     = m_c;
          y_nxt     = y_c;
          count_nxt = in_cnt;
          acc_nxt   = UW'(wsum);
          err_nxt   = 1'b0;
          state_nxt = S_WMOD;
        end
      end
      // weekday: reduce modulo 7, then branch on count and mask
      S_WMOD: begin
        if (uge) begin
          acc_nxt = udiff;
        end else begin
          wd_nxt = acc_r[2:0];
          if (kdays == 3'd0 && count_r != '0) begin
            err_nxt   = 1'b1;
            state_nxt = S_DONE;
          end else if (count_r == '0) begin
            acc_nxt   = UW'(raw_d_r);
            state_nxt = S_CMP1;
          end else begin
            state_nxt = S_CDEC;
          end
        end
      end
      S_CDEC: begin
        count_nxt = udiff[CW-1:0];
        rmd_nxt   = '0;
        cnt_nxt   = CNT_W'(CW - 1);
        state_nxt = S_DIV;
      end
      // restoring division of count-1 by the business days per week
      S_DIV: begin
        count_nxt = {count_r[CW-2:0], uge};
        rmd_nxt   = uge ? udiff[15:0] : ua[15:0];
        cnt_nxt   = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          r_nxt     = rmd_nxt[2:0] + 3'd1;
          ptr_nxt   = wd_r;
          cnt_nxt   = '0;
          state_nxt = S_POS;
        end
      end
      // find the r-th business day from the start weekday
      S_POS: begin
        ptr_nxt = (ptr_r == 3'd6) ? 3'd0 : ptr_r + 3'd1;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (mask_r[ptr_r]) begin
          if (r_r == 3'd1) begin
            pos_nxt   = cnt_r[2:0];
            state_nxt = S_MUL7;
          end else begin
            r_nxt = r_r - 3'd1;
          end
        end
      end
      S_MUL7: begin
        acc_nxt   = udiff;
        state_nxt = S_OFFD;
      end
      // offset plus start day
      S_OFFD: begin
        acc_nxt   = usum[UW-1:0];
        state_nxt = S_CMP1;
      end
      // stays in the start month or carries into the next
      S_CMP1: begin
        if (ugt) begin
          acc_nxt   = udiff;
          m_nxt     = m_inc;
          y_nxt     = y_inc;
          state_nxt = S_RDEC;
        end else begin
          end_day_nxt = acc_r[4:0];
          state_nxt   = S_DONE;
        end
      end
      S_RDEC: begin
        acc_nxt   = udiff;
        rmd_nxt   = '0;
        cnt_nxt   = CNT_W'(ACC_W - 1);
        state_nxt = S_RMOD;
      end
      // remainder modulo the hundred-year cycle, one bit a step
      S_RMOD: begin
        rmd_nxt = uge ? udiff[15:0] : ua[15:0];
        acc_nxt = {acc_r[UW-2:0], 1'b0};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) state_nxt = S_RINC;
      end
      S_RINC: begin
        acc_nxt   = usum[UW-1:0];
        state_nxt = S_QUAD;
      end
      // skip whole four-year spans, then years, then months
      S_QUAD: begin
        if (ugt) begin
          acc_nxt = udiff;
          y_nxt   = y_quad;
        end else begin
          state_nxt = S_YEAR;
        end
      end
      S_YEAR: begin
        if (ugt) begin
          acc_nxt = udiff;
          y_nxt   = (y_r == 7'(LAST_YEAR)) ? 7'd0 : y_r + 7'd1;
        end else begin
          state_nxt = S_MON;
        end
      end
      S_MON: begin
        if (ugt) begin
          acc_nxt = udiff;
          m_nxt   = m_inc;
          y_nxt   = y_inc;
        end else begin
          end_day_nxt = acc_r[4:0];
          state_nxt   = S_DONE;
        end
      end
      // load the output register once it is free
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_err_nxt   = err_r;
          if (err_r) out_data_nxt = {wd_r, raw_y_r, raw_d_r, raw_m_r};
          else       out_data_nxt = {wd_r, y_r, end_day_r, m_r};
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      mask_r      <= MASK_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) mask_r <= cfg_wr_data;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    raw_m_r    <= raw_m_nxt;
    raw_d_r    <= raw_d_nxt;
    raw_y_r    <= raw_y_nxt;
    m_r        <= m_nxt;
    y_r        <= y_nxt;
    count_r    <= count_nxt;
    err_r      <= err_nxt;
    wd_r       <= wd_nxt;
    r_r        <= r_nxt;
    ptr_r      <= ptr_nxt;
    pos_r      <= pos_nxt;
    acc_r      <= acc_nxt;
    rmd_r      <= rmd_nxt;
    cnt_r      <= cnt_nxt;
    end_day_r  <= end_day_nxt;
    out_data_r <= out_data_nxt;
    out_err_r  <= out_err_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b00000, out_data_r};
  assign out_tuser  = out_err_r;

  // the weekday scan always has a business day left to find
  a_scan_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_POS |-> r_r != 3'd0)
    else $error("weekday scan with zero count left");

  // a flagged result only comes from an empty mask
  a_err_mask: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> mask_r == 7'd0)
    else $error("mask error with nonempty mask");

  // start weekday is a real weekday
  a_wd_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[18:16] != 3'd7)
    else $error("start weekday out of range");

  // computed end month is a real month
  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[3:0] != 4'd0 && out_tdata[3:0] <= 4'd12)
    else $error("end month out of range");

endmodule
